>>> rtl/spbte_pkg.sv
`default_nettype none
package spbte_pkg;

  localparam int FRAME_LEN = 6;
  localparam int MAX_ATTEMPTS_DEF = 2;
  localparam int TIMER_BITS_DEF = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_TX     = 3'd0,
    KIND_QDONE  = 3'd1,
    KIND_WDONE  = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_BCAST  = 3'd4,
    KIND_BUSY   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_REPLY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_DOMAIN    = 3'd0,
    REG_OWN       = 3'd1,
    REG_MAIN      = 3'd2,
    REG_BCAST     = 3'd3,
    REG_QUERY     = 3'd4,
    REG_IDLE_SEND = 3'd5,
    REG_TIMEOUT   = 3'd6,
    REG_QUIET     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] param_code;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] param_out;
    logic [7:0] value_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] domain_code;
    logic [7:0] own_id;
    logic [7:0] mainboard_id;
    logic [7:0] broadcast_id;
    logic [7:0] query_code;
    logic [7:0] idle_before_send;
    logic [7:0] reply_timeout;
    logic [7:0] reply_quiet;
  } cfg_t;

  // One job for the back end: either a single result or a six-byte frame.
  typedef struct packed {
    logic       is_frame;
    out_item_t  single;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/spbte_front.sv
`default_nettype none
module spbte_front #(
  parameter int MAX_ATTEMPTS = spbte_pkg::MAX_ATTEMPTS_DEF,
  parameter int TIMER_BITS   = spbte_pkg::TIMER_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spbte_pkg::cfg_t     cfg,
  input  wire logic                in_fire,
  input  wire spbte_pkg::in_item_t item,
  output spbte_pkg::job_t          job,
  output logic                     job_valid
);
  import spbte_pkg::*;

  localparam int AW = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS + 1) : 1;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  phase_t                phase, phase_next;
  logic                  is_write, is_write_next;
  logic [7:0]            pending_param, pending_param_next;
  logic [7:0]            pending_data, pending_data_next;
  logic [7:0]            sent_checksum, sent_checksum_next;
  logic [AW-1:0]         attempts_used, attempts_used_next;
  logic [TIMER_BITS-1:0] since_send, since_send_next;
  logic [TIMER_BITS-1:0] since_activity, since_activity_next;
  logic [7:0]            frame_bytes [5];
  logic [2:0]            frame_position, frame_position_next, pos;
  logic                  fb_we;

  logic [TIMER_BITS-1:0] ss_b, sa_b;
  logic [TIMER_BITS:0]   idle_ext, to_ext, quiet_ext;
  logic [7:0]            f3, f4, fsum, rsum;
  logic                  do_tx;

  always_comb begin
    idle_ext  = (TIMER_BITS+1)'(cfg.idle_before_send);
    to_ext    = (TIMER_BITS+1)'(cfg.reply_timeout);
    quiet_ext = (TIMER_BITS+1)'(cfg.reply_quiet);
    ss_b = (since_send == TMAX) ? TMAX : since_send + 1'b1;
    sa_b = (since_activity == TMAX) ? TMAX : since_activity + 1'b1;
    rsum = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3]
         + frame_bytes[4];
  end

  always_comb begin
    phase_next          = phase;
    is_write_next       = is_write;
    pending_param_next  = pending_param;
    pending_data_next   = pending_data;
    sent_checksum_next  = sent_checksum;
    attempts_used_next  = attempts_used;
    since_send_next     = since_send;
    since_activity_next = since_activity;
    frame_position_next = frame_position;
    fb_we               = 1'b0;
    pos                 = frame_position;
    do_tx               = 1'b0;
    job_valid           = 1'b0;
    job                 = '0;
    if (in_fire) begin
      unique case (cmd_t'(item.cmd))
        CMD_TICK: begin
          since_send_next     = ss_b;
          since_activity_next = sa_b;
          if (phase == PH_WAIT) begin
            if ({1'b0, sa_b} >= idle_ext) do_tx = 1'b1;
          end else if (phase == PH_REPLY) begin
            if ({1'b0, ss_b} > to_ext && {1'b0, sa_b} > quiet_ext) begin
              attempts_used_next = attempts_used + 1'b1;
              if (32'(attempts_used_next) < MAX_ATTEMPTS) begin
                do_tx = 1'b1;
              end else begin
                phase_next = PH_IDLE;
                job_valid  = 1'b1;
                job.single = '{out_kind: KIND_FAIL, tx_byte: '0, tx_last: 1'b0,
                               param_out: pending_param, value_out: '0};
              end
            end
          end
        end
        CMD_BYTE: begin
          if ({1'b0, since_activity} >= quiet_ext || frame_position > 3'd5) pos = '0;
          since_activity_next = '0;
          if (phase == PH_REPLY && is_write && item.rx_byte == sent_checksum) begin
            phase_next          = PH_IDLE;
            frame_position_next = '0;
            job_valid           = 1'b1;
            job.single = '{out_kind: KIND_WDONE, tx_byte: '0, tx_last: 1'b0,
                           param_out: pending_param, value_out: '0};
          end else if (pos < 3'd5) begin
            fb_we               = 1'b1;
            frame_position_next = pos + 3'd1;
          end else begin
            frame_position_next = '0;
            if (phase == PH_REPLY) begin
              if (!is_write && frame_bytes[0] == cfg.domain_code &&
                  frame_bytes[1] == cfg.mainboard_id && frame_bytes[2] == cfg.own_id &&
                  frame_bytes[3] == pending_param && item.rx_byte == rsum) begin
                phase_next = PH_IDLE;
                job_valid  = 1'b1;
                job.single = '{out_kind: KIND_QDONE, tx_byte: '0, tx_last: 1'b0,
                               param_out: pending_param, value_out: frame_bytes[4]};
              end
            end else if (phase != PH_WAIT) begin
              if (frame_bytes[0] == cfg.domain_code && item.rx_byte == rsum &&
                  (frame_bytes[2] == cfg.broadcast_id || frame_bytes[2] == cfg.own_id)) begin
                job_valid  = 1'b1;
                job.single = '{out_kind: KIND_BCAST, tx_byte: '0, tx_last: 1'b0,
                               param_out: frame_bytes[3], value_out: frame_bytes[4]};
              end
            end
          end
        end
        CMD_QUERY, CMD_WRITE: begin
          if (phase != PH_IDLE) begin
            job_valid  = 1'b1;
            job.single = '{out_kind: KIND_BUSY, tx_byte: '0, tx_last: 1'b0,
                           param_out: item.param_code, value_out: '0};
          end else begin
            is_write_next      = (item.cmd == CMD_WRITE);
            pending_param_next = item.param_code;
            pending_data_next  = (item.cmd == CMD_WRITE) ? item.write_value : 8'd0;
            attempts_used_next = '0;
            if ({1'b0, since_activity} >= idle_ext) do_tx = 1'b1;
            else phase_next = PH_WAIT;
          end
        end
        default: ;
      endcase
    end
    f3   = is_write_next ? pending_param_next : cfg.query_code;
    f4   = is_write_next ? pending_data_next : pending_param_next;
    fsum = cfg.domain_code + cfg.own_id + cfg.mainboard_id + f3 + f4;
    if (do_tx) begin
      sent_checksum_next  = fsum;
      phase_next          = PH_REPLY;
      since_send_next     = '0;
      since_activity_next = '0;
      job_valid           = 1'b1;
      job.is_frame        = 1'b1;
      job.single.param_out = pending_param_next;
      job.b0 = cfg.domain_code;
      job.b1 = cfg.own_id;
      job.b2 = cfg.mainboard_id;
      job.b3 = f3;
      job.b4 = f4;
      job.b5 = fsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_write       <= 1'b0;
      pending_param  <= '0;
      pending_data   <= '0;
      sent_checksum  <= '0;
      attempts_used  <= '0;
      since_send     <= '0;
      since_activity <= TMAX;
      frame_position <= '0;
    end else begin
      phase          <= (phase_next == PH_IDLE || phase_next == PH_WAIT ||
                         phase_next == PH_REPLY) ? phase_next : PH_IDLE;
      is_write       <= is_write_next;
      pending_param  <= pending_param_next;
      pending_data   <= pending_data_next;
      sent_checksum  <= sent_checksum_next;
      attempts_used  <= attempts_used_next;
      since_send     <= since_send_next;
      since_activity <= since_activity_next;
      frame_position <= frame_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) frame_bytes[pos] <= item.rx_byte;
  end

endmodule
`default_nettype wire

>>> rtl/spbte_queue.sv
`default_nettype none
module spbte_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire spbte_pkg::job_t wdata,
  output logic                 has_room,
  input  wire logic            rd,
  output spbte_pkg::job_t      rdata,
  output logic                 not_empty
);
  import spbte_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign has_room  = (count < (PW+1)'(QUEUE_DEPTH - 1));
  assign not_empty = (count != '0);
  assign rdata     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule
`default_nettype wire

>>> rtl/spbte_back.sv
`default_nettype none
module spbte_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spbte_pkg::job_t  job,
  input  wire logic             job_valid,
  output logic                  job_pop,
  output spbte_pkg::out_item_t  result,
  output logic                  result_valid,
  input  wire logic             result_ready
);
  import spbte_pkg::*;

  logic [2:0] idx;
  logic [7:0] b;
  logic       take;

  always_comb begin
    case (idx)
      3'd0: b = job.b0;
      3'd1: b = job.b1;
      3'd2: b = job.b2;
      3'd3: b = job.b3;
      3'd4: b = job.b4;
      default: b = job.b5;
    endcase
    take    = job_valid && (!result_valid || result_ready);
    job_pop = take && (!job.is_frame || idx == 3'(FRAME_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        result_valid <= 1'b1;
        idx <= job_pop ? 3'd0 : idx + 3'd1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (job.is_frame) begin
        result <= '{out_kind: KIND_TX, tx_byte: b,
                    tx_last: (idx == 3'(FRAME_LEN - 1)),
                    param_out: job.single.param_out, value_out: '0};
      end else begin
        result <= job.single;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/serial_param_bus_transaction_engine.sv
// Path: each result passes the job queue and the output register. Throughput: one item per cycle;
// a frame transmission drains as 6 transfers at one per cycle while out_ready is high, so the
// input stalls while the 4-entry job queue between front and back holds 3 or more jobs.
// Reset: synchronous, active high; registers return to their reset values, bus deemed quiet.
`default_nettype none
module serial_param_bus_transaction_engine #(
  parameter int MAX_ATTEMPTS = spbte_pkg::MAX_ATTEMPTS_DEF,
  parameter int TIMER_BITS   = spbte_pkg::TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire spbte_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output spbte_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import spbte_pkg::*;

  cfg_t cfg;
  job_t fjob, qjob;
  logic fvalid, room, qne, pop, in_fire;

  assign in_ready  = room;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{domain_code: 8'd1, own_id: 8'd34, mainboard_id: 8'd17,
               broadcast_id: 8'd16, query_code: 8'd0, idle_before_send: 8'd5,
               reply_timeout: 8'd20, reply_quiet: 8'd3};
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DOMAIN:    cfg.domain_code      <= cfg_data;
        REG_OWN:       cfg.own_id           <= cfg_data;
        REG_MAIN:      cfg.mainboard_id     <= cfg_data;
        REG_BCAST:     cfg.broadcast_id     <= cfg_data;
        REG_QUERY:     cfg.query_code       <= cfg_data;
        REG_IDLE_SEND: cfg.idle_before_send <= cfg_data;
        REG_TIMEOUT:   cfg.reply_timeout    <= cfg_data;
        REG_QUIET:     cfg.reply_quiet      <= cfg_data;
        default: ;
      endcase
    end
  end

  spbte_front #(.MAX_ATTEMPTS(MAX_ATTEMPTS), .TIMER_BITS(TIMER_BITS)) u_front (
    .clk, .rst, .cfg, .in_fire, .item(in_data), .job(fjob), .job_valid(fvalid)
  );

  spbte_queue u_queue (
    .clk, .rst, .wr(fvalid), .wdata(fjob), .has_room(room),
    .rd(pop), .rdata(qjob), .not_empty(qne)
  );

  spbte_back u_back (
    .clk, .rst, .job(qjob), .job_valid(qne), .job_pop(pop),
    .result(out_data), .result_valid(out_valid), .result_ready(out_ready)
  );

endmodule
`default_nettype wire

>>> rtl/spbte_checker.sv
`default_nettype none
module spbte_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire spbte_pkg::out_item_t out_data
);
  import spbte_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_kind <= KIND_BUSY)
    else $error("bad result kind");

  a_last_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tx_last |-> out_data.out_kind == KIND_TX)
    else $error("last flag on non-transmit");

  a_nontx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind != KIND_TX |-> out_data.tx_byte == 8'd0)
    else $error("transmit byte on non-transmit");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind serial_param_bus_transaction_engine spbte_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data
);
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spbte_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  serial_param_bus_transaction_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the engine
  cfg_t       m_cfg;
  cfg_t       m_cfg_snap;
  phase_t     m_phase;
  logic       m_is_write;
  logic [7:0] m_param, m_data, m_sum;
  int         m_attempts;
  logic [7:0] m_since_send, m_since_act;
  logic [7:0] m_frame [5];
  int         m_pos;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  bit        quiet_mode = 1'b0;
  bit        hold_off_req = 1'b0;
  bit        stim_done = 1'b0;
  bit        in_taken = 1'b0;
  int        idle_cnt = 0;

  function automatic out_item_t mk(kind_t k, logic [7:0] tx, logic last,
                                   logic [7:0] p, logic [7:0] v);
    out_item_t r;
    r.out_kind = k; r.tx_byte = tx; r.tx_last = last; r.param_out = p; r.value_out = v;
    return r;
  endfunction

  function automatic logic [7:0] bump8(logic [7:0] t);
    return (t == 8'hff) ? t : t + 8'd1;
  endfunction

  task automatic send_frame();
    logic [7:0] f [6];
    f[0] = m_cfg.domain_code;
    f[1] = m_cfg.own_id;
    f[2] = m_cfg.mainboard_id;
    f[3] = m_is_write ? m_param : m_cfg.query_code;
    f[4] = m_is_write ? m_data : m_param;
    f[5] = f[0] + f[1] + f[2] + f[3] + f[4];
    m_sum = f[5];
    for (int i = 0; i < 6; i++)
      expected_results.push_back(mk(KIND_TX, f[i], i == 5, m_param, 8'd0));
    m_phase = PH_REPLY;
    m_since_send = 8'd0;
    m_since_act = 8'd0;
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [7:0] s;
    if (m_since_act >= m_cfg.reply_quiet || m_pos > 5) m_pos = 0;
    m_since_act = 8'd0;
    if (m_phase == PH_REPLY && m_is_write && b == m_sum) begin
      expected_results.push_back(mk(KIND_WDONE, 8'd0, 1'b0, m_param, 8'd0));
      m_phase = PH_IDLE;
      m_pos = 0;
      return;
    end
    if (m_pos < 5) begin
      m_frame[m_pos] = b;
      m_pos++;
      return;
    end
    m_pos = 0;
    s = m_frame[0] + m_frame[1] + m_frame[2] + m_frame[3] + m_frame[4];
    if (m_phase == PH_REPLY) begin
      if (!m_is_write && m_frame[0] == m_cfg.domain_code && m_frame[1] == m_cfg.mainboard_id
          && m_frame[2] == m_cfg.own_id && m_frame[3] == m_param && b == s) begin
        expected_results.push_back(mk(KIND_QDONE, 8'd0, 1'b0, m_param, m_frame[4]));
        m_phase = PH_IDLE;
      end
    end else if (m_phase != PH_WAIT) begin
      if (m_frame[0] == m_cfg.domain_code && b == s &&
          (m_frame[2] == m_cfg.broadcast_id || m_frame[2] == m_cfg.own_id))
        expected_results.push_back(mk(KIND_BCAST, 8'd0, 1'b0, m_frame[3], m_frame[4]));
    end
  endtask

  task automatic predict_item(in_item_t it);
    case (cmd_t'(it.cmd))
      CMD_TICK: begin
        m_since_send = bump8(m_since_send);
        m_since_act = bump8(m_since_act);
        if (m_phase == PH_WAIT) begin
          if (m_since_act >= m_cfg.idle_before_send) send_frame();
        end else if (m_phase == PH_REPLY) begin
          if (m_since_send > m_cfg.reply_timeout && m_since_act > m_cfg.reply_quiet) begin
            m_attempts++;
            if (m_attempts < MAX_ATTEMPTS_DEF) send_frame();
            else begin
              expected_results.push_back(mk(KIND_FAIL, 8'd0, 1'b0, m_param, 8'd0));
              m_phase = PH_IDLE;
            end
          end
        end
      end
      CMD_BYTE: take_byte(it.rx_byte);
      default: begin
        if (m_phase != PH_IDLE)
          expected_results.push_back(mk(KIND_BUSY, 8'd0, 1'b0, it.param_code, 8'd0));
        else begin
          m_is_write = (cmd_t'(it.cmd) == CMD_WRITE);
          m_param = it.param_code;
          m_data = m_is_write ? it.write_value : 8'd0;
          m_attempts = 0;
          if (m_since_act >= m_cfg.idle_before_send) send_frame();
          else m_phase = PH_WAIT;
        end
      end
    endcase
  endtask

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        if (!quiet_mode && $urandom_range(0, 19) == 0) begin
          in_gap <= $urandom_range(1, 12);
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  int out_gap = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off_req && hold_cnt == 0) begin
        hold_cnt <= 300;
        hold_off_req <= 1'b0;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= (hold_cnt == 1);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= (out_gap == 1);
      end else if (!quiet_mode && $urandom_range(0, 14) == 0) begin
        out_gap <= $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.out_kind != out_data.out_kind || e.tx_byte != out_data.tx_byte ||
              e.tx_last != out_data.tx_last || e.param_out != out_data.param_out ||
              e.value_out != out_data.value_out) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p actual %p", e, out_data);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DOMAIN:    m_cfg.domain_code = v;
      REG_OWN:       m_cfg.own_id = v;
      REG_MAIN:      m_cfg.mainboard_id = v;
      REG_BCAST:     m_cfg.broadcast_id = v;
      REG_QUERY:     m_cfg.query_code = v;
      REG_IDLE_SEND: m_cfg.idle_before_send = v;
      REG_TIMEOUT:   m_cfg.reply_timeout = v;
      default:       m_cfg.reply_quiet = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk_in(cmd_t c, logic [7:0] rx, logic [7:0] p, logic [7:0] v);
    in_item_t r;
    r.cmd = c; r.rx_byte = rx; r.param_code = p; r.write_value = v;
    return r;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(mk_in(CMD_TICK, rnd8(), rnd8(), rnd8()));
  endtask

  // bytes of a frame; corrupt flags a bad checksum
  task automatic push_frame(logic [7:0] d, logic [7:0] s, logic [7:0] r, logic [7:0] p,
                            logic [7:0] v, bit corrupt);
    logic [7:0] f [6];
    f[0] = d; f[1] = s; f[2] = r; f[3] = p; f[4] = v;
    f[5] = d + s + r + p + v + (corrupt ? 8'd1 : 8'd0);
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk_in(CMD_BYTE, f[i], rnd8(), rnd8()));
  endtask

  task automatic push_random_txn();
    int sel;
    logic [7:0] p, v, s;
    sel = $urandom_range(0, 9);
    p = rnd8();
    v = rnd8();
    push_ticks($urandom_range(0, 8));
    if (sel < 3) begin
      pending_items.push_back(mk_in(CMD_QUERY, rnd8(), p, v));
      push_ticks($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0)
        pending_items.push_back(mk_in(cmd_t'($urandom_range(2, 3)), rnd8(), rnd8(), rnd8()));
      if ($urandom_range(0, 4) != 0)
        push_frame(m_cfg_snap.domain_code, m_cfg_snap.mainboard_id, m_cfg_snap.own_id, p, v,
                   $urandom_range(0, 7) == 0);
      else
        push_ticks($urandom_range(10, 60));
    end else if (sel < 6) begin
      pending_items.push_back(mk_in(CMD_WRITE, rnd8(), p, v));
      push_ticks($urandom_range(0, 3));
      s = m_cfg_snap.domain_code + m_cfg_snap.own_id + m_cfg_snap.mainboard_id + p + v;
      if ($urandom_range(0, 4) != 0)
        pending_items.push_back(mk_in(CMD_BYTE, s, rnd8(), rnd8()));
      else
        push_ticks($urandom_range(10, 60));
    end else if (sel < 8) begin
      push_frame(m_cfg_snap.domain_code, rnd8(),
                 $urandom_range(0, 1) ? m_cfg_snap.broadcast_id : m_cfg_snap.own_id,
                 p, v, $urandom_range(0, 5) == 0);
    end else begin
      pending_items.push_back(mk_in(cmd_t'($urandom_range(0, 3)), rnd8(), p, v));
    end
  endtask

  task automatic reset_shadow();
    m_cfg = '{8'd1, 8'd34, 8'd17, 8'd16, 8'd0, 8'd5, 8'd20, 8'd3};
    m_phase = PH_IDLE;
    m_is_write = 1'b0; m_param = 8'd0; m_data = 8'd0; m_sum = 8'd0; m_attempts = 0;
    m_since_send = 8'd0; m_since_act = 8'hff; m_pos = 0;
    for (int i = 0; i < 5; i++) m_frame[i] = 8'd0;
  endtask

  task automatic random_phase(int n);
    m_cfg_snap = m_cfg;
    for (int i = 0; i < n; i++) push_random_txn();
    wait_drain();
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part with reset settings
    m_cfg_snap = m_cfg;
    pending_items.push_back(mk_in(CMD_QUERY, 8'h00, 8'h05, 8'h00));
    pending_items.push_back(mk_in(CMD_WRITE, 8'hff, 8'hff, 8'hff));
    push_frame(8'd1, 8'd17, 8'd34, 8'h05, 8'h5a, 0);
    pending_items.push_back(mk_in(CMD_WRITE, 8'h00, 8'hff, 8'hff));
    push_ticks(50);
    pending_items.push_back(mk_in(CMD_BYTE, 8'hff, 8'h00, 8'h00));
    push_frame(8'd1, 8'd99, 8'd16, 8'h00, 8'hff, 0);
    push_ticks(4);
    push_frame(8'd1, 8'd99, 8'd34, 8'hff, 8'h00, 1);
    wait_drain();

    write_reg(REG_IDLE_SEND, 8'd1);
    write_reg(REG_TIMEOUT, 8'd1);
    write_reg(REG_QUIET, 8'd1);
    hold_off_req = 1'b1;
    random_phase(5);

    write_reg(REG_DOMAIN, 8'hff);
    write_reg(REG_OWN, 8'h00);
    write_reg(REG_MAIN, 8'hff);
    write_reg(REG_BCAST, 8'h00);
    write_reg(REG_QUERY, 8'hff);
    write_reg(REG_IDLE_SEND, 8'd255);
    write_reg(REG_TIMEOUT, 8'd255);
    write_reg(REG_QUIET, 8'd255);
    random_phase(3);

    write_reg(REG_DOMAIN, 8'd1);
    write_reg(REG_OWN, 8'd34);
    write_reg(REG_MAIN, 8'd17);
    write_reg(REG_BCAST, 8'd16);
    write_reg(REG_QUERY, 8'd0);
    write_reg(REG_IDLE_SEND, 8'd3);
    write_reg(REG_TIMEOUT, 8'd6);
    write_reg(REG_QUIET, 8'd2);
    random_phase(4);

    quiet_mode = 1'b1;
    random_phase(2);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

>>> serial_param_bus_transaction_engine.f
rtl/spbte_pkg.sv
rtl/spbte_front.sv
rtl/spbte_queue.sv
rtl/spbte_back.sv
rtl/serial_param_bus_transaction_engine.sv
rtl/spbte_checker.sv
dv/tb_top.sv
